// ===== src/block_pixelate_average_defines.svh =====
// Assertion macros used by the block pixelate average controller.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef BLOCK_PIXELATE_AVERAGE_DEFINES_SVH
`define BLOCK_PIXELATE_AVERAGE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpa assertion failed");

// Antecedent implies consequent in the next cycle.
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpa assertion failed");

`endif

// ===== src/bpa_pkg.sv =====
// Package for the block pixelate average: sizes, types and codes.
// Used by the divider, datapath, controller and top level.
package bpa_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int BLOCK_COLUMNS = 2048;
    localparam int SLOT_W        = $clog2(BLOCK_COLUMNS);
    localparam int SUM_W         = 24;
    localparam int CNT_W         = 17;
    localparam int DIV_STEPS     = SUM_W;
    localparam int STEP_W        = $clog2(DIV_STEPS);
    localparam int POS_W         = 12;
    localparam int SIZE_W        = 13;
    localparam int CFG_DATA_W    = 15;
    localparam int CFG_INDEX_W   = 3;
    localparam logic [7:0] DEFAULT_BLOCK = 8'd8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SURFACE_WIDTH  = 3'd0,
        REG_SURFACE_HEIGHT = 3'd1,
        REG_REGION_LEFT    = 3'd2,
        REG_REGION_TOP     = 3'd3,
        REG_REGION_RIGHT   = 3'd4,
        REG_REGION_BOTTOM  = 3'd5,
        REG_BLOCK_SIZE     = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic load_pix;
        logic div_load_geo;
        logic div_load_mean;
        logic div_step;
        logic geo_latch;
        logic accum;
        logic out_load;
    } bpa_cmd_t;

    typedef struct packed {
        logic in_region;
        logic block_end;
        logic out_full;
    } bpa_status_t;

    typedef struct packed {
        logic [SUM_W-1:0] blue_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] red_sum;
        logic [CNT_W-1:0] count;
    } bpa_entry_t;

endpackage

// ===== src/block_pixelate_average.sv =====
// Block pixelate average. Each pixel is checked against the region; inside it
// follow a 24-step offset division, a memory read and an accumulate; when a block
// ends, a 24-step mean division and an output load, held while the output is full.
// Pixels are taken only in idle, also while a result waits in the output register.
// rst_n clears control state, position and configuration (1920 x 1080, block 8);
// the block sum memory is not cleared; a block's first pixel restarts its entry.
module block_pixelate_average
    import bpa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             blue,
    input  logic [7:0]             green,
    input  logic [7:0]             red,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             avg_blue,
    output logic [7:0]             avg_green,
    output logic [7:0]             avg_red,
    output logic [POS_W-1:0]       block_column,
    output logic [POS_W-1:0]       block_row,
    output logic [7:0]             block_width,
    output logic [7:0]             block_height,
    output logic                   last_block,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bpa_cmd_t    cmd;
    bpa_status_t status;

    assign cfg_ready = 1'b1;

    bpa_control u_control (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .status(status), .cmd(cmd)
    );

    bpa_datapath u_datapath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .blue(blue), .green(green), .red(red),
        .out_ready(out_ready), .out_valid(out_valid),
        .avg_blue(avg_blue), .avg_green(avg_green), .avg_red(avg_red),
        .block_column(block_column), .block_row(block_row),
        .block_width(block_width), .block_height(block_height),
        .last_block(last_block)
    );

endmodule

// ===== src/bpa_divider.sv =====
// Restoring divider lane, one quotient bit per step.
// Depends on bpa_pkg for the dividend and divisor widths.
module bpa_divider
    import bpa_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output logic [CNT_W-1:0] remainder
);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg;
    logic [CNT_W:0]   rem_shift;
    logic             fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        quo_next  = {quo_reg[SUM_W-2:0], fits};
        if (fits)
        begin
            rem_next = CNT_W'(rem_shift - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = rem_shift[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/bpa_datapath.sv =====
// Datapath: configuration, raster position, block sum memory, divider lanes
// and the output register. Depends on bpa_pkg and bpa_divider.
module bpa_datapath
    import bpa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bpa_cmd_t               cmd,
    output bpa_status_t            status,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             blue,
    input  logic [7:0]             green,
    input  logic [7:0]             red,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [7:0]             avg_blue,
    output logic [7:0]             avg_green,
    output logic [7:0]             avg_red,
    output logic [POS_W-1:0]       block_column,
    output logic [POS_W-1:0]       block_row,
    output logic [7:0]             block_width,
    output logic [7:0]             block_height,
    output logic                   last_block
);

    // Configuration registers.
    logic [SIZE_W-1:0]        sw_cfg_reg, sh_cfg_reg;
    logic signed [13:0]       left_reg, top_reg;
    logic signed [14:0]       right_reg, bottom_reg;
    logic [7:0]               bsize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_cfg_reg <= SIZE_W'(1920);
            sh_cfg_reg <= SIZE_W'(1080);
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            bsize_reg  <= DEFAULT_BLOCK;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SURFACE_WIDTH:  sw_cfg_reg <= cfg_data[SIZE_W-1:0];
                REG_SURFACE_HEIGHT: sh_cfg_reg <= cfg_data[SIZE_W-1:0];
                REG_REGION_LEFT:    left_reg   <= cfg_data[13:0];
                REG_REGION_TOP:     top_reg    <= cfg_data[13:0];
                REG_REGION_RIGHT:   right_reg  <= cfg_data[14:0];
                REG_REGION_BOTTOM:  bottom_reg <= cfg_data[14:0];
                REG_BLOCK_SIZE:     bsize_reg  <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // Effective geometry; the region bounds are 16-bit signed for the compares.
    logic [SIZE_W-1:0]  sw_eff, sh_eff;
    logic [7:0]         bs_eff;
    logic signed [15:0] x0, y0, x1, y1;

    always_comb
    begin
        if (sw_cfg_reg == '0)
            sw_eff = SIZE_W'(1);
        else if (sw_cfg_reg > SIZE_W'(MAX_WIDTH))
            sw_eff = SIZE_W'(MAX_WIDTH);
        else
            sw_eff = sw_cfg_reg;
        if (sh_cfg_reg == '0)
            sh_eff = SIZE_W'(1);
        else if (sh_cfg_reg > SIZE_W'(MAX_HEIGHT))
            sh_eff = SIZE_W'(MAX_HEIGHT);
        else
            sh_eff = sh_cfg_reg;
        bs_eff = (bsize_reg < 8'd2) ? DEFAULT_BLOCK : bsize_reg;
        x0 = (left_reg < 0) ? 16'sd0 : 16'(left_reg);
        y0 = (top_reg < 0) ? 16'sd0 : 16'(top_reg);
        x1 = (16'(right_reg) > $signed({3'b0, sw_eff})) ? $signed({3'b0, sw_eff})
                                                        : 16'(right_reg);
        y1 = (16'(bottom_reg) > $signed({3'b0, sh_eff})) ? $signed({3'b0, sh_eff})
                                                         : 16'(bottom_reg);
    end

    // Raster position of the next pixel.
    logic [POS_W-1:0] col_reg, col_next, row_reg, row_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.load_pix)
        begin
            if (({1'b0, col_reg} + 1'b1) >= sw_eff)
            begin
                col_next = '0;
                if (({1'b0, row_reg} + 1'b1) >= sh_eff)
                    row_next = '0;
                else
                    row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Latched pixel.
    logic               in_region_reg;
    logic [POS_W-1:0]   wcol_reg, wrow_reg, dx_reg, dy_reg;
    logic [7:0]         pb_reg, pg_reg, pr_reg;
    logic signed [15:0] c16, r16;

    assign c16 = $signed({4'b0, col_reg});
    assign r16 = $signed({4'b0, row_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_region_reg <= 1'b0;
        else if (cmd.load_pix)
            in_region_reg <= (c16 >= x0) && (c16 < x1) && (r16 >= y0) && (r16 < y1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            wcol_reg <= col_reg;
            wrow_reg <= row_reg;
            dx_reg   <= POS_W'(c16 - x0);
            dy_reg   <= POS_W'(r16 - y0);
            pb_reg   <= blue;
            pg_reg   <= green;
            pr_reg   <= red;
        end
    end

    // Three divider lanes: blocks offsets first, then the colour means.
    bpa_entry_t       new_entry;
    logic [SUM_W-1:0] quo_b, quo_g, quo_r;
    logic [CNT_W-1:0] rem_b, rem_g, rem_r;
    logic [SUM_W-1:0] dvd_b, dvd_g, dvd_r;
    logic [CNT_W-1:0] dvs;
    logic             lane_load;

    assign lane_load = cmd.div_load_geo | cmd.div_load_mean;

    always_comb
    begin
        if (cmd.div_load_geo)
        begin
            dvd_b = SUM_W'(dx_reg);
            dvd_g = SUM_W'(dy_reg);
            dvd_r = '0;
            dvs   = CNT_W'(bs_eff);
        end
        else
        begin
            dvd_b = new_entry.blue_sum;
            dvd_g = new_entry.green_sum;
            dvd_r = new_entry.red_sum;
            dvs   = new_entry.count;
        end
    end

    bpa_divider u_div_blue (
        .clk(clk), .load(lane_load), .step(cmd.div_step),
        .dividend(dvd_b), .divisor(dvs), .quotient(quo_b), .remainder(rem_b)
    );
    bpa_divider u_div_green (
        .clk(clk), .load(lane_load), .step(cmd.div_step),
        .dividend(dvd_g), .divisor(dvs), .quotient(quo_g), .remainder(rem_g)
    );
    bpa_divider u_div_red (
        .clk(clk), .load(lane_load), .step(cmd.div_step),
        .dividend(dvd_r), .divisor(dvs), .quotient(quo_r), .remainder(rem_r)
    );

    // Block sum memory, one entry per block column.
    bpa_entry_t        mem [BLOCK_COLUMNS];
    bpa_entry_t        rdata_reg;
    logic [7:0]        ox_reg, oy_reg;
    logic [SLOT_W-1:0] slot_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.geo_latch)
        begin
            ox_reg    <= rem_b[7:0];
            oy_reg    <= rem_g[7:0];
            slot_reg  <= quo_b[SLOT_W-1:0];
            rdata_reg <= mem[quo_b[SLOT_W-1:0]];
        end
        if (cmd.accum)
            mem[slot_reg] <= new_entry;
    end

    always_comb
    begin
        if ((ox_reg == '0) && (oy_reg == '0))
        begin
            new_entry.blue_sum  = SUM_W'(pb_reg);
            new_entry.green_sum = SUM_W'(pg_reg);
            new_entry.red_sum   = SUM_W'(pr_reg);
            new_entry.count     = CNT_W'(1);
        end
        else
        begin
            new_entry.blue_sum  = rdata_reg.blue_sum + SUM_W'(pb_reg);
            new_entry.green_sum = rdata_reg.green_sum + SUM_W'(pg_reg);
            new_entry.red_sum   = rdata_reg.red_sum + SUM_W'(pr_reg);
            new_entry.count     = rdata_reg.count + 1'b1;
        end
    end

    // Block end and extent, taken from the latched pixel.
    logic signed [15:0] wc16, wr16, bx16, by16, bw16, bh16;
    logic               last_x, last_y, end_x, end_y;
    logic [POS_W-1:0]   bx, by;
    logic [7:0]         bw, bh;

    always_comb
    begin
        wc16   = $signed({4'b0, wcol_reg});
        wr16   = $signed({4'b0, wrow_reg});
        last_x = wc16 == (x1 - 16'sd1);
        last_y = wr16 == (y1 - 16'sd1);
        end_x  = (ox_reg == (bs_eff - 8'd1)) || last_x;
        end_y  = (oy_reg == (bs_eff - 8'd1)) || last_y;
        bx     = wcol_reg - POS_W'(ox_reg);
        by     = wrow_reg - POS_W'(oy_reg);
        bx16   = $signed({4'b0, bx});
        by16   = $signed({4'b0, by});
        bw16   = x1 - bx16;
        bh16   = y1 - by16;
        bw     = (bw16 > $signed({8'b0, bs_eff})) ? bs_eff : bw16[7:0];
        bh     = (bh16 > $signed({8'b0, bs_eff})) ? bs_eff : bh16[7:0];
    end

    logic             end_reg, last_reg, zero_cnt_reg;
    logic [POS_W-1:0] bx_reg, by_reg;
    logic [7:0]       bw_reg, bh_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accum)
        begin
            end_reg      <= end_x && end_y;
            last_reg     <= last_x && last_y;
            zero_cnt_reg <= new_entry.count == '0;
            bx_reg       <= bx;
            by_reg       <= by;
            bw_reg       <= bw;
            bh_reg       <= bh;
        end
    end

    // Output register.
    logic       out_valid_reg;
    logic [7:0] ab_reg, ag_reg, ar_reg, bw_out_reg, bh_out_reg;
    logic [POS_W-1:0] bx_out_reg, by_out_reg;
    logic       last_out_reg;

    function automatic logic [7:0] sat_mean(input logic [SUM_W-1:0] q, input logic zero);
        logic [7:0] m;
        if (zero)
            m = '0;
        else if (|q[SUM_W-1:8])
            m = 8'hFF;
        else
            m = q[7:0];
        return m;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ab_reg       <= sat_mean(quo_b, zero_cnt_reg);
            ag_reg       <= sat_mean(quo_g, zero_cnt_reg);
            ar_reg       <= sat_mean(quo_r, zero_cnt_reg);
            bx_out_reg   <= bx_reg;
            by_out_reg   <= by_reg;
            bw_out_reg   <= bw_reg;
            bh_out_reg   <= bh_reg;
            last_out_reg <= last_reg;
        end
    end

    assign status.in_region = in_region_reg;
    assign status.block_end = end_x && end_y;
    assign status.out_full  = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign avg_blue     = ab_reg;
    assign avg_green    = ag_reg;
    assign avg_red      = ar_reg;
    assign block_column = bx_out_reg;
    assign block_row    = by_out_reg;
    assign block_width  = bw_out_reg;
    assign block_height = bh_out_reg;
    assign last_block   = last_out_reg;

endmodule

// ===== src/bpa_control.sv =====
// Controller state machine sequencing one pixel through the datapath.
// Depends on bpa_pkg and the assertion macros header.
`include "block_pixelate_average_defines.svh"
module bpa_control
    import bpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bpa_status_t status,
    output bpa_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CHECK = 7'b0000010,
        ST_GEO   = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_ACCUM = 7'b0010000,
        ST_MEAN  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              last_step;

    assign last_step = step_reg == STEP_W'(DIV_STEPS - 1);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.in_region)
                begin
                    cmd.div_load_geo = 1'b1;
                    step_next        = '0;
                    state_next       = ST_GEO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GEO:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.geo_latch = 1'b1;
                state_next    = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (status.block_end)
                begin
                    cmd.div_load_mean = 1'b1;
                    step_next         = '0;
                    state_next        = ST_MEAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEAN:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (last_step)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Wait until the previous result beat has left the output register.
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `BPA_ASSERT_SAME(a_load_free, cmd.out_load, !status.out_full)
    `BPA_ASSERT_NEXT(a_accept_check, in_valid && in_ready, state_reg == ST_CHECK)
    `BPA_ASSERT_NEXT(a_geo_read, (state_reg == ST_GEO) && last_step, state_reg == ST_READ)
    `BPA_ASSERT_SAME(a_ready_idle, in_ready, (state_reg == ST_IDLE) && !cmd.div_step)

endmodule

// ===== tb/tb_block_pixelate_average.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for block_pixelate_average: whole frames of pixels,
// a built-in block-average predictor and a result scoreboard. Needs bpa_pkg.
module tb_block_pixelate_average;
    import bpa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 100;

    typedef struct packed {
        logic [7:0]       avg_blue;
        logic [7:0]       avg_green;
        logic [7:0]       avg_red;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic [7:0]       width;
        logic [7:0]       height;
        logic             last;
    } block_mean_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [7:0]             blue = '0, green = '0, red = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [7:0]             avg_blue, avg_green, avg_red;
    logic [POS_W-1:0]       block_column, block_row;
    logic [7:0]             block_width, block_height;
    logic                   last_block;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    block_pixelate_average u_dut (.*);

    always #10 clk = ~clk;

    // Predictor state.
    int          surf_w = 1920, surf_h = 1080, edge_len = 8;
    int          reg_left = 0, reg_top = 0, reg_right = 0, reg_bottom = 0;
    int          cur_col = 0, cur_row = 0;
    int          sum_b [BLOCK_COLUMNS];
    int          sum_g [BLOCK_COLUMNS];
    int          sum_r [BLOCK_COLUMNS];
    int          pix_cnt [BLOCK_COLUMNS];
    block_mean_t pending_means [$];

    int idle_pct = 0, stall_pct = 0;
    bit hold_off = 1'b0;
    int mismatches = 0, cycles = 0, pixels_sent = 0;

    function automatic int clamp_dim(int v);
        return (v < 1) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : v);
    endfunction

    function automatic int sign_ext(int v, int bits);
        int x;
        x = v & ((1 << bits) - 1);
        return (x >= (1 << (bits - 1))) ? x - (1 << bits) : x;
    endfunction

    function automatic logic [7:0] mean_of(int sum, int cnt);
        int q;
        if (cnt == 0)
        begin
            return 8'd0;
        end
        q = sum / cnt;
        return (q > 255) ? 8'hFF : q[7:0];
    endfunction

    task automatic accumulate_pixel(input logic [7:0] b, input logic [7:0] g,
                                    input logic [7:0] r);
        int sw, sh, bs, x0, y0, x1, y1, dx, dy, ox, oy, slot, bx, by, bw, bh;
        block_mean_t m;
        sw = clamp_dim(surf_w);
        sh = clamp_dim(surf_h);
        bs = (edge_len < 2) ? 8 : edge_len;
        x0 = (reg_left < 0) ? 0 : reg_left;
        y0 = (reg_top < 0) ? 0 : reg_top;
        x1 = (reg_right > sw) ? sw : reg_right;
        y1 = (reg_bottom > sh) ? sh : reg_bottom;
        if (cur_col >= x0 && cur_col < x1 && cur_row >= y0 && cur_row < y1)
        begin
            dx = cur_col - x0;
            dy = cur_row - y0;
            ox = dx % bs;
            oy = dy % bs;
            slot = (dx / bs) % BLOCK_COLUMNS;
            if (ox == 0 && oy == 0)
            begin
                sum_b[slot] = b;
                sum_g[slot] = g;
                sum_r[slot] = r;
                pix_cnt[slot] = 1;
            end
            else
            begin
                sum_b[slot] = (sum_b[slot] + b) & 24'hFFFFFF;
                sum_g[slot] = (sum_g[slot] + g) & 24'hFFFFFF;
                sum_r[slot] = (sum_r[slot] + r) & 24'hFFFFFF;
                pix_cnt[slot] = (pix_cnt[slot] + 1) & 17'h1FFFF;
            end
            if ((ox == bs - 1 || cur_col == x1 - 1) && (oy == bs - 1 || cur_row == y1 - 1))
            begin
                bx = cur_col - ox;
                by = cur_row - oy;
                bw = (x1 - bx > bs) ? bs : x1 - bx;
                bh = (y1 - by > bs) ? bs : y1 - by;
                m.avg_blue  = mean_of(sum_b[slot], pix_cnt[slot]);
                m.avg_green = mean_of(sum_g[slot], pix_cnt[slot]);
                m.avg_red   = mean_of(sum_r[slot], pix_cnt[slot]);
                m.column    = bx[POS_W-1:0];
                m.row       = by[POS_W-1:0];
                m.width     = bw[7:0];
                m.height    = bh[7:0];
                m.last      = (cur_col == x1 - 1 && cur_row == y1 - 1);
                pending_means.push_back(m);
            end
        end
        if (cur_col + 1 >= sw)
        begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= sh) ? 0 : cur_row + 1;
        end
        else
        begin
            cur_col = cur_col + 1;
        end
    endtask

    // Called at a falling edge; returns at a falling edge.
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        blue <= b;
        green <= g;
        red <= r;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_pixel(b, g, r);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last beat.
    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_SURFACE_WIDTH:  surf_w = value & 13'h1FFF;
            REG_SURFACE_HEIGHT: surf_h = value & 13'h1FFF;
            REG_REGION_LEFT:    reg_left = sign_ext(value, 14);
            REG_REGION_TOP:     reg_top = sign_ext(value, 14);
            REG_REGION_RIGHT:   reg_right = sign_ext(value, 15);
            REG_REGION_BOTTOM:  reg_bottom = sign_ext(value, 15);
            default:            edge_len = value & 8'hFF;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_means.size() != 0)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b0;
        repeat (SETTLE) @(negedge clk);
    endtask

    // Configure, then stream one whole frame so the raster position ends at
    // the origin again. Pattern 1 uses only full and empty bytes, others are random.
    task automatic run_frame(input int w, input int h, input int l, input int t,
                             input int rt, input int bt, input int bs, input int pattern);
        int n;
        wait_drained();
        write_reg(REG_SURFACE_WIDTH, w);
        write_reg(REG_SURFACE_HEIGHT, h);
        write_reg(REG_REGION_LEFT, l);
        write_reg(REG_REGION_TOP, t);
        write_reg(REG_REGION_RIGHT, rt);
        write_reg(REG_REGION_BOTTOM, bt);
        write_reg(REG_BLOCK_SIZE, bs);
        cfg_valid <= 1'b0;
        n = clamp_dim(w & 13'h1FFF) * clamp_dim(h & 13'h1FFF);
        for (int i = 0; i < n; i++)
        begin
            if (pattern == 1)
            begin
                send_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'hFF : 8'h00,
                           (i % 2) ? 8'h00 : 8'hFF);
            end
            else
            begin
                send_pixel($urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        // Block size 0 means 8, clipped by a 5 x 5 surface; region overhangs.
        run_frame(5, 5, -3, -2, 100, 100, 0, 1);
        // Zero width and height count as one pixel.
        run_frame(0, 0, 0, 0, 1, 1, 1, 1);
        // Empty region: left past right.
        run_frame(3, 2, 2, 0, 1, 2, 2, 0);
    endtask

    task automatic test_wide_surface();
        // Region runs past the right edge; the largest block is clipped by it.
        idle_pct = 14;
        stall_pct = 14;
        run_frame(600, 1, 400, -4096, 8192, 8192, 255, 0);
    endtask

    task automatic test_random_frames();
        int w, h, l, t, bs, phase;
        phase = 0;
        while (pixels_sent < 1950)
        begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            w = $urandom_range(16, 1);
            h = $urandom_range(12, 1);
            l = $urandom_range(w, 0) - $urandom_range(4, 0);
            t = $urandom_range(h, 0) - $urandom_range(4, 0);
            bs = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12, 2);
            if ($urandom_range(5) == 0)
            begin
                run_frame(w, h, -4096, -4096, 8192, 8192, bs, 0);
            end
            else
            begin
                run_frame(w, h, l, t, l + $urandom_range(w + 4, 1),
                          t + $urandom_range(h + 4, 1), bs, 0);
            end
            phase++;
        end
    endtask

    task automatic test_output_hold_off();
        idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge clk);
                hold_off = 1'b0;
            end
        join_none
        run_frame(16, 8, 0, 0, 16, 8, 2, 0);
    endtask

    always @(negedge clk)
    begin
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        block_mean_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = '{avg_blue, avg_green, avg_red, block_column, block_row,
                    block_width, block_height, last_block};
            if (pending_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pending_means.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_wide_surface();
        test_output_hold_off();
        test_random_frames();
        wait_drained();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/bpa_pkg.sv
src/bpa_divider.sv
src/bpa_datapath.sv
src/bpa_control.sv
src/block_pixelate_average.sv
tb/tb_block_pixelate_average.sv
